// File: sv/bitmap_glyph_renderer_with_clipping_top_defines.svh
// Assertion macros for the glyph renderer.
`ifndef BITMAP_GLYPH_RENDERER_WITH_CLIPPING_TOP_DEFINES_SVH
`define BITMAP_GLYPH_RENDERER_WITH_CLIPPING_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define BGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BGR_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BGR_ASSERT(label, prop, msg)

`define BGR_ASSERT_NR(label, prop, msg)

`endif

`endif

// File: sv/bgr_pkg.sv
package bgr_pkg;

  localparam int GLYPH_ROWS_DEF = 12;
  localparam int GLYPH_COLS     = 8;
  localparam int ROM_ROWS       = 12;
  localparam int ROM_AW         = $clog2(ROM_ROWS);

  localparam logic [15:0] WIDE_CODE_LIMIT = 16'd128;
  localparam logic [15:0] SUBST_CODE      = 16'h003F;
  localparam logic [15:0] CODE_DIGIT0     = 16'h0030;
  localparam logic [15:0] CODE_DIGIT1     = 16'h0031;
  localparam logic [15:0] CODE_CAP_A      = 16'h0041;
  localparam logic [15:0] CODE_CAP_B      = 16'h0042;
  localparam logic [15:0] CODE_CAP_C      = 16'h0043;

  localparam logic [15:0] RST_PIXEL_COLOR   = 16'd0;
  localparam logic [15:0] RST_CLIP_LEFT     = 16'd0;
  localparam logic [15:0] RST_CLIP_TOP      = 16'd0;
  localparam logic [15:0] RST_CLIP_RIGHT    = 16'd2047;
  localparam logic [15:0] RST_CLIP_BOTTOM   = 16'd2047;
  localparam logic [11:0] RST_BUFFER_WIDTH  = 12'd480;
  localparam logic [11:0] RST_BUFFER_HEIGHT = 12'd272;

  typedef enum logic [2:0] {
    CFG_PIXEL_COLOR   = 3'd0,
    CFG_CLIP_LEFT     = 3'd1,
    CFG_CLIP_TOP      = 3'd2,
    CFG_CLIP_RIGHT    = 3'd3,
    CFG_CLIP_BOTTOM   = 3'd4,
    CFG_BUFFER_WIDTH  = 3'd5,
    CFG_BUFFER_HEIGHT = 3'd6
  } cfg_reg_t;

  localparam logic [7:0] GLYPH_DIGIT0 [ROM_ROWS] =
    '{8'h3E, 8'h63, 8'h73, 8'h7B, 8'h6F, 8'h67, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] GLYPH_DIGIT1 [ROM_ROWS] =
    '{8'h0C, 8'h1C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] GLYPH_CAP_A [ROM_ROWS] =
    '{8'h1C, 8'h36, 8'h63, 8'h7F, 8'h63, 8'h63, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] GLYPH_CAP_B [ROM_ROWS] =
    '{8'h7E, 8'h63, 8'h63, 8'h7E, 8'h63, 8'h63, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] GLYPH_CAP_C [ROM_ROWS] =
    '{8'h3C, 8'h66, 8'h60, 8'h60, 8'h60, 8'h66, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  // One row of the glyph ROM. Wide codes are drawn as the substitute code,
  // which has no glyph of its own; rows past the stored ones are blank.
  function automatic logic [7:0] glyph_row(input logic [15:0] code, input logic [5:0] row);
    logic [15:0]       c;
    logic [ROM_AW-1:0] idx;
    logic [7:0]        bits;
    c    = (code >= WIDE_CODE_LIMIT) ? SUBST_CODE : code;
    idx  = row[ROM_AW-1:0];
    bits = 8'h00;
    if (row < 6'(ROM_ROWS)) begin
      case (c)
        CODE_DIGIT0: bits = GLYPH_DIGIT0[idx];
        CODE_DIGIT1: bits = GLYPH_DIGIT1[idx];
        CODE_CAP_A:  bits = GLYPH_CAP_A[idx];
        CODE_CAP_B:  bits = GLYPH_CAP_B[idx];
        CODE_CAP_C:  bits = GLYPH_CAP_C[idx];
        default:     bits = 8'h00;
      endcase
    end
    return bits;
  endfunction

endpackage

// File: sv/bitmap_glyph_renderer_with_clipping_top.sv
// A character's row results pass through the character registers, the issue stage (glyph
// ROM read), the pending row register and the output register. The glyph ROM gives one row
// per cycle while the output does not stall, and a new character is accepted while the last
// row of the current one is read; a stalled output holds the pipeline only when a further
// result must be delivered.
// Synchronous active-low reset restores register defaults, clears the cursor and pipeline.
`include "bitmap_glyph_renderer_with_clipping_top_defines.svh"

module bitmap_glyph_renderer_with_clipping_top #(
  parameter int GLYPH_ROWS = bgr_pkg::GLYPH_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_char_code,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic               in_new_string,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        out_row_y,
  output logic signed [15:0] out_column_x,
  output logic [7:0]         out_write_mask,
  output logic signed [23:0] out_row_address,
  output logic [15:0]        out_write_color,
  output logic               out_last
);

  localparam int RW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_ROWS - 1);

  // Configuration registers.
  logic [15:0]        pixel_color_r;
  logic signed [15:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [11:0]        buffer_width_r, buffer_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_color_r   <= bgr_pkg::RST_PIXEL_COLOR;
      clip_left_r     <= bgr_pkg::RST_CLIP_LEFT;
      clip_top_r      <= bgr_pkg::RST_CLIP_TOP;
      clip_right_r    <= bgr_pkg::RST_CLIP_RIGHT;
      clip_bottom_r   <= bgr_pkg::RST_CLIP_BOTTOM;
      buffer_width_r  <= bgr_pkg::RST_BUFFER_WIDTH;
      buffer_height_r <= bgr_pkg::RST_BUFFER_HEIGHT;
    end else if (cfg_we) begin
      case (bgr_pkg::cfg_reg_t'(cfg_index))
        bgr_pkg::CFG_PIXEL_COLOR:   pixel_color_r   <= cfg_wdata;
        bgr_pkg::CFG_CLIP_LEFT:     clip_left_r     <= cfg_wdata;
        bgr_pkg::CFG_CLIP_TOP:      clip_top_r      <= cfg_wdata;
        bgr_pkg::CFG_CLIP_RIGHT:    clip_right_r    <= cfg_wdata;
        bgr_pkg::CFG_CLIP_BOTTOM:   clip_bottom_r   <= cfg_wdata;
        bgr_pkg::CFG_BUFFER_WIDTH:  buffer_width_r  <= cfg_wdata[11:0];
        bgr_pkg::CFG_BUFFER_HEIGHT: buffer_height_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Row sequencer and cursor.
  logic               busy_r;
  logic [RW-1:0]      row_r;
  logic [15:0]        code_r;
  logic signed [15:0] cx_r, cy_r;
  logic signed [15:0] cursor_x_r, string_y_r;
  logic signed [15:0] cx_nxt, cy_nxt;
  logic               row_last;
  logic               adv;
  logic               in_xfer;

  assign row_last = (row_r == LAST_ROW);
  assign in_ready = adv && (!busy_r || row_last);
  assign in_xfer  = in_valid && in_ready;
  assign cx_nxt   = in_new_string ? in_start_x : cursor_x_r;
  assign cy_nxt   = in_new_string ? in_start_y : string_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      row_r      <= '0;
      cursor_x_r <= '0;
      string_y_r <= '0;
    end else if (adv) begin
      if (in_xfer) begin
        busy_r     <= 1'b1;
        row_r      <= '0;
        cursor_x_r <= cx_nxt + 16'sd8;
        string_y_r <= cy_nxt;
      end else if (busy_r) begin
        if (row_last) begin
          busy_r <= 1'b0;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_xfer) begin
      code_r <= in_char_code;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
    end
  end

  // Column clipping depends on the character's column and the clip and width registers, not on the row.
  logic [7:0] col_mask;

  always_comb begin
    logic signed [16:0] px;
    col_mask = '0;
    for (int c = 0; c < bgr_pkg::GLYPH_COLS; c++) begin
      px = {cx_r[15], cx_r} + $signed(17'(c));
      col_mask[7-c] = !px[16]
                   && (px >= $signed({clip_left_r[15], clip_left_r}))
                   && (px <= $signed({clip_right_r[15], clip_right_r}))
                   && (px < $signed({5'b0, buffer_width_r}));
    end
  end

  // Issue stage: glyph ROM read with registered data, row coordinate.
  logic               a_valid_r;
  logic               a_end_r;
  logic [7:0]         rom_row_r;
  logic [7:0]         a_col_mask_r;
  logic signed [16:0] a_py_r;
  logic signed [15:0] a_cx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rom_row_r    <= bgr_pkg::glyph_row(code_r, 6'(row_r));
      a_end_r      <= row_last;
      a_col_mask_r <= col_mask;
      a_py_r       <= {cy_r[15], cy_r} + $signed(17'(row_r));
      a_cx_r       <= cx_r;
    end
  end

  // Row clipping, write mask and address.
  logic        b_yok;
  logic [7:0]  b_mask;
  logic        b_nz;
  logic [23:0] b_prod;
  logic [23:0] b_addr;

  assign b_yok  = !a_py_r[16]
               && (a_py_r >= $signed({clip_top_r[15], clip_top_r}))
               && (a_py_r <= $signed({clip_bottom_r[15], clip_bottom_r}))
               && (a_py_r < $signed({5'b0, buffer_height_r}));
  assign b_mask = b_yok ? (rom_row_r & a_col_mask_r) : 8'h00;
  assign b_nz   = a_valid_r && (b_mask != 8'h00);
  assign b_prod = 24'(a_py_r[11:0]) * 24'(buffer_width_r);
  assign b_addr = b_prod + {{8{a_cx_r[15]}}, a_cx_r};

  // Pending row: held until the next written row or the end of the character
  // shows whether it is the last one.
  logic               p_valid_r;
  logic               p_final_r;
  logic [10:0]        p_row_y_r;
  logic signed [15:0] p_cx_r;
  logic [7:0]         p_mask_r;
  logic [23:0]        p_addr_r;
  logic               emit;
  logic               emit_last;
  logic               stall;

  assign emit      = p_valid_r && (p_final_r || (a_valid_r && (b_nz || a_end_r)));
  assign emit_last = p_final_r || !b_nz;
  assign stall     = emit && out_valid && !out_ready;
  assign adv       = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      p_final_r <= 1'b0;
    end else if (adv) begin
      if (b_nz) begin
        p_valid_r <= 1'b1;
        p_final_r <= a_end_r;
      end else if (emit) begin
        p_valid_r <= 1'b0;
        p_final_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_nz) begin
      p_row_y_r <= a_py_r[10:0];
      p_cx_r    <= a_cx_r;
      p_mask_r  <= b_mask;
      p_addr_r  <= b_addr;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_row_y       <= p_row_y_r;
      out_column_x    <= p_cx_r;
      out_write_mask  <= p_mask_r;
      out_row_address <= p_addr_r;
      out_write_color <= pixel_color_r;
      out_last        <= emit_last;
    end
  end

  `BGR_ASSERT_NR(a_reset_empty, !rst_n |=> !busy_r && !out_valid && !p_valid_r, "reset must empty the pipeline")
  `BGR_ASSERT(a_stall_holds_pending, stall |=> p_valid_r && $stable(p_mask_r) && $stable(p_addr_r), "pending row lost during output stall")
  `BGR_ASSERT(a_out_mask_nonzero, out_valid |-> out_write_mask != 8'h00, "row result with empty write mask")
  `BGR_ASSERT(a_row_in_range, busy_r |-> row_r <= LAST_ROW, "row counter out of range")

endmodule

// File: dv/bitmap_glyph_renderer_with_clipping_top_test.sv
module bitmap_glyph_renderer_with_clipping_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CHAR_ROWS        = bgr_pkg::GLYPH_ROWS_DEF;
  localparam int          SETTLE_CYCLES    = 3 + CHAR_ROWS + 9;
  localparam int          CYCLE_LIMIT      = 400000;
  localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;

  typedef struct {
    logic [10:0]        row_y;
    logic signed [15:0] column_x;
    logic [7:0]         write_mask;
    logic signed [23:0] row_address;
    logic [15:0]        write_color;
    logic               last;
  } row_write_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               cfg_we          = 1'b0;
  logic [2:0]         cfg_index       = '0;
  logic [15:0]        cfg_wdata       = '0;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic [15:0]        in_char_code    = '0;
  logic signed [15:0] in_start_x      = '0;
  logic signed [15:0] in_start_y      = '0;
  logic               in_new_string   = 1'b0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic [10:0]        out_row_y;
  logic signed [15:0] out_column_x;
  logic [7:0]         out_write_mask;
  logic signed [23:0] out_row_address;
  logic [15:0]        out_write_color;
  logic               out_last;

  // Register copy and cursor of the predictor.
  logic [15:0]        pix_color  = bgr_pkg::RST_PIXEL_COLOR;
  logic signed [15:0] clip_l     = bgr_pkg::RST_CLIP_LEFT;
  logic signed [15:0] clip_t     = bgr_pkg::RST_CLIP_TOP;
  logic signed [15:0] clip_r     = bgr_pkg::RST_CLIP_RIGHT;
  logic signed [15:0] clip_b     = bgr_pkg::RST_CLIP_BOTTOM;
  logic [11:0]        buf_w      = bgr_pkg::RST_BUFFER_WIDTH;
  logic [11:0]        buf_h      = bgr_pkg::RST_BUFFER_HEIGHT;
  logic signed [15:0] cursor_col = '0;
  logic signed [15:0] string_row = '0;

  row_write_t rows_pending[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  bit         bursts_on   = 1'b0;

  bitmap_glyph_renderer_with_clipping_top #(
    .GLYPH_ROWS(CHAR_ROWS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_new_string  (in_new_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_y      (out_row_y),
    .out_column_x   (out_column_x),
    .out_write_mask (out_write_mask),
    .out_row_address(out_row_address),
    .out_write_color(out_write_color),
    .out_last       (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bitmap_glyph_renderer_with_clipping_top");
      $finish;
    end
  end

  // Output back-pressure in random bursts while bursts are on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9);
    end
    out_ready <= (stall_left == 0);
  end

  // Computes the row writes of one character and advances the cursor.
  function automatic void render_char(input logic [15:0] code, input logic signed [15:0] sx,
                                      input logic signed [15:0] sy, input logic ns);
    logic [15:0] eff_code;
    logic [95:0] glyph;
    logic [7:0]  row_bits;
    logic [7:0]  masks [CHAR_ROWS];
    int          r, c, cx, cy, py, px, bw, bh, addr, last_row;
    row_write_t  rw;
    if (ns) begin
      cursor_col = sx;
      string_row = sy;
    end
    eff_code = (code >= bgr_pkg::WIDE_CODE_LIMIT) ? bgr_pkg::SUBST_CODE : code;
    case (eff_code)
      bgr_pkg::CODE_DIGIT0: glyph = 96'h3E_63_73_7B_6F_67_3E_00_00_00_00_00;
      bgr_pkg::CODE_DIGIT1: glyph = 96'h0C_1C_0C_0C_0C_0C_3E_00_00_00_00_00;
      bgr_pkg::CODE_CAP_A:  glyph = 96'h1C_36_63_7F_63_63_63_00_00_00_00_00;
      bgr_pkg::CODE_CAP_B:  glyph = 96'h7E_63_63_7E_63_63_7E_00_00_00_00_00;
      bgr_pkg::CODE_CAP_C:  glyph = 96'h3C_66_60_60_60_66_3C_00_00_00_00_00;
      default:              glyph = '0;
    endcase
    cx = 32'(cursor_col);
    cy = 32'(string_row);
    bw = 32'(buf_w);
    bh = 32'(buf_h);
    last_row = -1;
    for (r = 0; r < CHAR_ROWS; r++) begin
      masks[r] = 8'h00;
      py = cy + r;
      row_bits = (r < bgr_pkg::ROM_ROWS) ? glyph[95 - 8 * r -: 8] : 8'h00;
      if (py >= 0 && py >= clip_t && py <= clip_b && py < bh) begin
        for (c = 0; c < 8; c++) begin
          px = cx + c;
          if (px >= 0 && px >= clip_l && px <= clip_r && px < bw && row_bits[7 - c])
            masks[r][7 - c] = 1'b1;
        end
      end
      if (masks[r] != 8'h00) last_row = r;
    end
    for (r = 0; r < CHAR_ROWS; r++) begin
      if (masks[r] != 8'h00) begin
        py             = cy + r;
        addr           = py * bw + cx;
        rw.row_y       = py[10:0];
        rw.column_x    = cursor_col;
        rw.write_mask  = masks[r];
        rw.row_address = addr[23:0];
        rw.write_color = pix_color;
        rw.last        = (r == last_row);
        rows_pending.push_back(rw);
      end
    end
    cursor_col = cursor_col + 16'sd8;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    row_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rows_pending.size() == 0) begin
        $error("row result with nothing pending: row_y %0d mask %h", out_row_y, out_write_mask);
        mismatches++;
      end else begin
        want = rows_pending.pop_front();
        check_field("row_y", 32'(want.row_y), 32'(out_row_y));
        check_field("column_x", 32'(want.column_x), 32'(out_column_x));
        check_field("write_mask", 32'(want.write_mask), 32'(out_write_mask));
        check_field("row_address", 32'(want.row_address), 32'(out_row_address));
        check_field("write_color", 32'(want.write_color), 32'(out_write_color));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Leaves in_valid high after the transfer so back-to-back characters need
  // only one assignment per edge; a gap lowers it first.
  task automatic send_char(input logic [15:0] code, input logic signed [15:0] sx,
                           input logic signed [15:0] sy, input logic ns);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= code;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_new_string <= ns;
    render_char(code, sx, sy, ns);
    do @(posedge clk); while (!in_ready);
  endtask

  // A blank character may still be in flight after the last row arrives.
  task automatic wait_rows_done();
    in_valid <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      bgr_pkg::CFG_PIXEL_COLOR:   pix_color = data;
      bgr_pkg::CFG_CLIP_LEFT:     clip_l    = data;
      bgr_pkg::CFG_CLIP_TOP:      clip_t    = data;
      bgr_pkg::CFG_CLIP_RIGHT:    clip_r    = data;
      bgr_pkg::CFG_CLIP_BOTTOM:   clip_b    = data;
      bgr_pkg::CFG_BUFFER_WIDTH:  buf_w     = data[11:0];
      bgr_pkg::CFG_BUFFER_HEIGHT: buf_h     = data[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic set_open_clip();
    write_reg(bgr_pkg::CFG_CLIP_LEFT, 16'h8000);
    write_reg(bgr_pkg::CFG_CLIP_TOP, 16'h8000);
    write_reg(bgr_pkg::CFG_CLIP_RIGHT, 16'h7FFF);
    write_reg(bgr_pkg::CFG_CLIP_BOTTOM, 16'h7FFF);
  endtask

  task automatic test_reset_defaults();
    send_char(bgr_pkg::CODE_CAP_A, 16'sd0, 16'sd0, 1'b1);
    send_char(bgr_pkg::CODE_DIGIT0, 16'sd0, 16'sd0, 1'b0);
    send_char(bgr_pkg::CODE_DIGIT1, 16'sd0, 16'sd0, 1'b0);
    send_char(bgr_pkg::CODE_CAP_B, 16'sd0, 16'sd0, 1'b0);
    send_char(bgr_pkg::CODE_CAP_C, 16'sd0, 16'sd0, 1'b0);
    wait_rows_done();
  endtask

  // Wide codes and codes without a glyph draw nothing but still move the cursor.
  task automatic test_wide_and_blank();
    send_char(16'hFFFF, 16'sd100, 16'sd50, 1'b1);
    send_char(bgr_pkg::WIDE_CODE_LIMIT, 16'sd0, 16'sd0, 1'b0);
    send_char(bgr_pkg::WIDE_CODE_LIMIT - 16'd1, 16'sd0, 16'sd0, 1'b0);
    send_char(bgr_pkg::SUBST_CODE, 16'sd0, 16'sd0, 1'b0);
    send_char(16'h0000, 16'sd0, 16'sd0, 1'b0);
    send_char(bgr_pkg::CODE_CAP_A, 16'sd0, 16'sd0, 1'b0);
    wait_rows_done();
  endtask

  task automatic test_clipping();
    write_reg(bgr_pkg::CFG_PIXEL_COLOR, 16'hA5C3);
    write_reg(bgr_pkg::CFG_CLIP_LEFT, 16'sd3);
    write_reg(bgr_pkg::CFG_CLIP_TOP, 16'sd2);
    write_reg(bgr_pkg::CFG_CLIP_RIGHT, 16'sd12);
    write_reg(bgr_pkg::CFG_CLIP_BOTTOM, 16'sd8);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_B, 16'sd0, 16'sd0, 1'b1);
    send_char(bgr_pkg::CODE_CAP_C, 16'sd0, 16'sd0, 1'b0);
    wait_rows_done();
    // With the clip rectangle wide open, negative coordinates must still clip.
    set_open_clip();
    end_writes();
    send_char(bgr_pkg::CODE_DIGIT0, -16'sd4, -16'sd3, 1'b1);
    wait_rows_done();
    write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'd20);
    write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'd10);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_A, 16'sd16, 16'sd5, 1'b1);
    send_char(bgr_pkg::CODE_CAP_C, 16'sd0, 16'sd0, 1'b0);
    wait_rows_done();
  endtask

  task automatic test_extremes();
    write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'd0);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_A, 16'sd0, 16'sd0, 1'b1);
    wait_rows_done();
    write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'd8);
    write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'd0);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_A, 16'sd0, 16'sd0, 1'b1);
    wait_rows_done();
    // Rows past 2047 wrap in row_y but not in the address.
    write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'hFFFF);
    write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'hFFFF);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_B, 16'sd4088, 16'sd2042, 1'b1);
    wait_rows_done();
    // The cursor wraps from the top column into negative columns.
    send_char(bgr_pkg::CODE_DIGIT0, 16'sd32760, 16'sd10, 1'b1);
    send_char(bgr_pkg::CODE_DIGIT1, 16'sd0, 16'sd0, 1'b0);
    wait_rows_done();
    write_reg(bgr_pkg::CFG_CLIP_LEFT, 16'h7FFF);
    write_reg(bgr_pkg::CFG_CLIP_RIGHT, 16'h8000);
    write_reg(bgr_pkg::CFG_CLIP_BOTTOM, 16'h8000);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_A, 16'sd0, 16'sd0, 1'b1);
    wait_rows_done();
    set_open_clip();
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    end_writes();
    send_char(bgr_pkg::CODE_CAP_A, 16'sd0, 16'sd0, 1'b1);
    wait_rows_done();
  endtask

  task automatic random_config();
    int lo_x, lo_y;
    write_reg(bgr_pkg::CFG_PIXEL_COLOR, 16'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      set_open_clip();
    end else begin
      lo_x = $urandom_range(0, 30) - 10;
      lo_y = $urandom_range(0, 20) - 10;
      write_reg(bgr_pkg::CFG_CLIP_LEFT, 16'(lo_x));
      write_reg(bgr_pkg::CFG_CLIP_TOP, 16'(lo_y));
      write_reg(bgr_pkg::CFG_CLIP_RIGHT, 16'(lo_x + $urandom_range(0, 120)));
      write_reg(bgr_pkg::CFG_CLIP_BOTTOM, 16'(lo_y + $urandom_range(0, 70)));
    end
    case ($urandom_range(0, 5))
      0:       write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'($urandom));
      1:       write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'd2048);
      2:       write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'd4095);
      default: write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'($urandom_range(1, 160)));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'($urandom));
      1:       write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'd2048);
      default: write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'($urandom_range(1, 80)));
    endcase
    end_writes();
  endtask

  // Mostly drawable glyphs near the visible area; the rest is raw noise.
  task automatic random_char(input bit first);
    logic [15:0] code;
    int          sx, sy;
    bit          ns;
    ns = first || ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 4))
        0:       code = bgr_pkg::CODE_DIGIT0;
        1:       code = bgr_pkg::CODE_DIGIT1;
        2:       code = bgr_pkg::CODE_CAP_A;
        3:       code = bgr_pkg::CODE_CAP_B;
        default: code = bgr_pkg::CODE_CAP_C;
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      code = 16'($urandom);
    end else begin
      code = 16'($urandom_range(0, 127));
    end
    if ($urandom_range(0, 9) == 0) begin
      sx = $urandom;
      sy = $urandom;
    end else begin
      sx = $urandom_range(0, 120) - 12;
      sy = $urandom_range(0, 70) - 12;
    end
    send_char(code, 16'(sx), 16'(sy), ns);
  endtask

  task automatic test_random();
    int phase;
    for (phase = 0; phase < 7; phase++) begin
      random_config();
      random_char(1'b1);
      repeat (41) random_char(1'b0);
      wait_rows_done();
    end
  endtask

  task automatic test_full_rate();
    bursts_on = 1'b0;
    set_open_clip();
    write_reg(bgr_pkg::CFG_BUFFER_WIDTH, 16'd2048);
    write_reg(bgr_pkg::CFG_BUFFER_HEIGHT, 16'd2048);
    end_writes();
    random_char(1'b1);
    repeat (39) random_char(1'b0);
    wait_rows_done();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    bursts_on = 1'b1;
    test_reset_defaults();
    test_wide_and_blank();
    test_clipping();
    test_extremes();
    test_random();
    test_full_rate();
    if (mismatches == 0) begin
      $display("PASS bitmap_glyph_renderer_with_clipping_top");
    end else begin
      $display("FAIL bitmap_glyph_renderer_with_clipping_top");
    end
    $finish;
  end

endmodule
